/* hdl/trpp_pkg.sv */
// trpp_pkg: shared types, opcodes and helper functions for the tftp packet parser
// no dependencies; imported by every module of the parser
package trpp_pkg;

	// transaction payloads
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} trpp_in_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  kind;
		logic        mode;
		logic [15:0] error_code;
		logic [9:0]  text_length;
	} trpp_out_t;

	// tftp opcodes
	localparam logic [15:0] OP_RRQ   = 16'd1;
	localparam logic [15:0] OP_WRQ   = 16'd2;
	localparam logic [15:0] OP_ERROR = 16'd5;

	// result codes
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic       MODE_NETASCII = 1'b0;
	localparam logic       MODE_OCTET    = 1'b1;

	// mode string lengths and the saturation point of the mode counter
	localparam logic [3:0] NETASCII_LEN = 4'd8;
	localparam logic [3:0] OCTET_LEN    = 4'd5;
	localparam logic [3:0] MLEN_SAT     = 4'd9;

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [9:0] TEXT_MAX = 10'h3FF;

	// lower-case a letter, leave anything else alone
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic is_upper;
		is_upper = (b >= 8'h41) && (b <= 8'h5A);
		return is_upper ? (b + 8'h20) : b;
	endfunction

	// characters of "netascii"
	function automatic logic [7:0] netascii_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h6E;
			3'd1: c = 8'h65;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h73;
			3'd5: c = 8'h63;
			3'd6: c = 8'h69;
			3'd7: c = 8'h69;
		endcase
		return c;
	endfunction

	// characters of "octet"; codes past the word mean nothing
	function automatic logic [7:0] octet_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h6F;
			3'd1: c = 8'h63;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* hdl/trpp_scan.sv */
// trpp_scan: per-packet scan state and the byte-by-byte checks
// depends on trpp_pkg; gives the packet verdict while the final byte is stepped
module trpp_scan #(
	parameter int PACKET_MAX = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  trpp_pkg::trpp_in_t byte_in,
	output trpp_pkg::trpp_out_t verdict
);
	import trpp_pkg::*;

	localparam int POS_W = $clog2(PACKET_MAX + 2);
	localparam int LEN_W = (POS_W > 10) ? POS_W : 10;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(PACKET_MAX);

	logic [POS_W-1:0] pos_q, pos_nx;
	logic [15:0]      op_q, op_nx;
	logic [15:0]      code_q, code_nx;
	logic [9:0]       flen_q, flen_nx;
	logic [1:0]       nulls_q, nulls_nx;
	logic [3:0]       mlen_q, mlen_nx;
	logic             na_q, na_nx;
	logic             oc_q, oc_nx;
	logic             pr_q, pr_nx;

	logic [7:0]       b;
	logic [7:0]       lb;
	logic             in_range;
	logic             is_null;
	logic             past_op;
	logic [LEN_W-1:0] p_ext;
	logic [LEN_W-1:0] p_minus2;
	logic [LEN_W-1:0] p_minus4;
	logic             is_req;
	logic             req_ok;
	logic             err_ok;

	assign b        = byte_in.data_byte;
	assign lb       = fold_case(b);
	assign in_range = pos_q < POS_MAX;
	assign is_null  = (b == 8'h00);
	assign past_op  = pos_q >= POS_W'(2);
	assign p_ext    = LEN_W'(pos_q);
	assign p_minus2 = p_ext - LEN_W'(2);
	assign p_minus4 = p_ext - LEN_W'(4);

	// next scan state for the byte being stepped
	always_comb begin
		pos_nx   = (pos_q <= POS_MAX) ? pos_q + POS_W'(1) : pos_q;
		op_nx    = op_q;
		code_nx  = code_q;
		flen_nx  = flen_q;
		nulls_nx = nulls_q;
		mlen_nx  = mlen_q;
		na_nx    = na_q;
		oc_nx    = oc_q;
		pr_nx    = pr_q;
		if (in_range) begin
			if (pos_q == POS_W'(0)) begin
				op_nx = {b, 8'h00};
			end else if (pos_q == POS_W'(1)) begin
				op_nx = {op_q[15:8], b};
			end else if (pos_q == POS_W'(2)) begin
				code_nx = {b, 8'h00};
			end else if (pos_q == POS_W'(3)) begin
				code_nx = {code_q[15:8], b};
			end
			// string separators and mode word tracking
			if (past_op) begin
				if (is_null) begin
					if (nulls_q == 2'd0) begin
						flen_nx = (p_minus2 > LEN_W'(TEXT_MAX)) ? TEXT_MAX : p_minus2[9:0];
					end
					if (nulls_q != 2'd3) begin
						nulls_nx = nulls_q + 2'd1;
					end
				end else if (nulls_q == 2'd1) begin
					if (mlen_q >= NETASCII_LEN || netascii_char(mlen_q[2:0]) != lb) begin
						na_nx = 1'b0;
					end
					if (mlen_q >= OCTET_LEN || octet_char(mlen_q[2:0]) != lb) begin
						oc_nx = 1'b0;
					end
					if (mlen_q != MLEN_SAT) begin
						mlen_nx = mlen_q + 4'd1;
					end
				end
			end
			// error text must stay printable up to the closing byte
			if (pos_q >= POS_W'(4) && !byte_in.is_last && (b < PRINT_LO || b > PRINT_HI)) begin
				pr_nx = 1'b0;
			end
		end
	end

	// verdict on the final byte
	assign is_req = (op_nx == OP_RRQ) || (op_nx == OP_WRQ);
	assign req_ok = in_range && is_req && pos_q >= POS_W'(4) && is_null && nulls_nx == 2'd2
		&& ((na_nx && mlen_nx == NETASCII_LEN) || (oc_nx && mlen_nx == OCTET_LEN));
	assign err_ok = in_range && op_nx == OP_ERROR && pos_q >= POS_W'(5) && is_null && pr_nx;

	always_comb begin
		verdict = '0;
		priority if (req_ok) begin
			verdict.accepted    = 1'b1;
			verdict.kind        = (op_nx == OP_RRQ) ? KIND_READ : KIND_WRITE;
			verdict.mode        = (na_nx && mlen_nx == NETASCII_LEN) ? MODE_NETASCII : MODE_OCTET;
			verdict.text_length = flen_nx;
		end else if (err_ok) begin
			verdict.accepted    = 1'b1;
			verdict.kind        = KIND_ERROR;
			verdict.error_code  = code_nx;
			verdict.text_length = (p_minus4 > LEN_W'(TEXT_MAX)) ? TEXT_MAX : p_minus4[9:0];
		end else begin
			verdict = '0;
		end
	end

	// scan state; cleared after the final byte of each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			op_q    <= '0;
			code_q  <= '0;
			flen_q  <= '0;
			nulls_q <= '0;
			mlen_q  <= '0;
			na_q    <= 1'b1;
			oc_q    <= 1'b1;
			pr_q    <= 1'b1;
		end else if (step) begin
			if (byte_in.is_last) begin
				pos_q   <= '0;
				op_q    <= '0;
				code_q  <= '0;
				flen_q  <= '0;
				nulls_q <= '0;
				mlen_q  <= '0;
				na_q    <= 1'b1;
				oc_q    <= 1'b1;
				pr_q    <= 1'b1;
			end else begin
				pos_q   <= pos_nx;
				op_q    <= op_nx;
				code_q  <= code_nx;
				flen_q  <= flen_nx;
				nulls_q <= nulls_nx;
				mlen_q  <= mlen_nx;
				na_q    <= na_nx;
				oc_q    <= oc_nx;
				pr_q    <= pr_nx;
			end
		end
	end

endmodule

/* hdl/trpp_out_stage.sv */
// trpp_out_stage: result register between the scan logic and the output channel
// depends on trpp_pkg
module trpp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  trpp_pkg::trpp_out_t load_data,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output trpp_pkg::trpp_out_t out_data
);
	import trpp_pkg::*;

	logic      valid_q;
	trpp_out_t data_q;

	// free when empty or when the held transaction leaves this cycle
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

/* hdl/tftp_request_packet_parser.sv */
// tftp_request_packet_parser: checks a udp payload, one byte per transaction, as a tftp
// rrq, wrq or error packet. the final byte enters the input register when taken and its
// result is loaded into the result register once that register can take it, then shown on
// out_valid. throughput: one byte per cycle; a byte waits only while the final byte of
// the next packet meets a result not yet taken.
// asynchronous active-low reset empties both registers and clears the scan state.
module tftp_request_packet_parser #(
	parameter int PACKET_MAX = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  trpp_pkg::trpp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output trpp_pkg::trpp_out_t out_data
);
	import trpp_pkg::*;

	logic      valid_s1;
	trpp_in_t  data_s1;
	logic      step;
	logic      can_load;
	logic      load;
	trpp_out_t verdict;

	// the held byte moves on unless it closes a packet and the result slot is busy
	assign step     = valid_s1 && (!data_s1.is_last || can_load);
	assign load     = step && data_s1.is_last;
	assign in_ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	trpp_scan #(
		.PACKET_MAX(PACKET_MAX)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (data_s1),
		.verdict (verdict)
	);

	trpp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (verdict),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a rejected packet reports all fields as zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.kind == KIND_READ
			&& out_data.mode == MODE_NETASCII && out_data.error_code == 16'd0
			&& out_data.text_length == 10'd0)
		else $error("rejected packet with non-zero fields");

	// error code only on error packets, mode only on requests
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_ERROR |-> out_data.error_code == 16'd0)
		else $error("error code on a request");

	a_error_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_ERROR |-> out_data.mode == MODE_NETASCII
			&& out_data.accepted)
		else $error("bad error packet fields");

	// input only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with free result slot");

endmodule

/* tb/tftp_request_packet_parser_tb.sv */
`timescale 1ns / 100ps
// tftp_request_packet_parser_tb: self-checking bench for the tftp rrq/wrq/error packet parser
// depends on trpp_pkg and tftp_request_packet_parser; needs nothing else
module tftp_request_packet_parser_tb;
	import trpp_pkg::*;

	localparam int PKT_MAX = 1024;
	localparam int RANDOM_BYTES = 200;
	localparam logic [63:0] NETASCII_WORD = "netascii";
	localparam logic [39:0] OCTET_WORD = "octet";

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	trpp_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	trpp_out_t out_data;

	tftp_request_packet_parser #(.PACKET_MAX(PKT_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// verdicts predicted for packets whose final byte has been taken
	trpp_out_t expected_verdicts[$];
	int mismatches = 0;

	// packet under construction
	logic [7:0] pkt_bytes[$];

	// sender burst control
	int burst_left = 4;
	bit steady_send = 1'b0;

	// receiver stall control
	int hold_ask = 0;
	int hold_left = 0;
	int rx_cycle = 0;

	// parser scan state kept by the predictor
	logic [10:0] scan_pos;
	logic [15:0] scan_opcode;
	logic [15:0] scan_code;
	logic [10:0] scan_name_len;
	logic [1:0]  scan_nulls;
	logic [10:0] scan_mode_len;
	logic        scan_netascii_ok;
	logic        scan_octet_ok;
	logic        scan_printable;

	task automatic clear_scan();
		scan_pos = '0;
		scan_opcode = '0;
		scan_code = '0;
		scan_name_len = '0;
		scan_nulls = '0;
		scan_mode_len = '0;
		scan_netascii_ok = 1'b1;
		scan_octet_ok = 1'b1;
		scan_printable = 1'b1;
	endtask

	// advance the scan by one byte; on the final byte queue the packet verdict
	task automatic predict_verdict(input logic [7:0] b, input logic last);
		int p;
		int len;
		logic [7:0] lb;
		trpp_out_t v;
		p = scan_pos;
		if (p < PKT_MAX) begin
			if (p == 0)
				scan_opcode = {b, 8'h00};
			else if (p == 1)
				scan_opcode[7:0] = b;
			else if (p == 2)
				scan_code = {b, 8'h00};
			else if (p == 3)
				scan_code[7:0] = b;
			if (p >= 2) begin
				if (b == 8'h00) begin
					if (scan_nulls == 2'd0)
						scan_name_len = 11'(p - 2);
					if (scan_nulls != 2'd3)
						scan_nulls = scan_nulls + 2'd1;
				end else if (scan_nulls == 2'd1) begin
					// mode letters compare without regard to case
					lb = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
					if (scan_mode_len >= 8)
						scan_netascii_ok = 1'b0;
					else if (NETASCII_WORD[63 - 8 * scan_mode_len -: 8] != lb)
						scan_netascii_ok = 1'b0;
					if (scan_mode_len >= 5)
						scan_octet_ok = 1'b0;
					else if (OCTET_WORD[39 - 8 * scan_mode_len -: 8] != lb)
						scan_octet_ok = 1'b0;
					if (scan_mode_len < 11'd2047)
						scan_mode_len = scan_mode_len + 11'd1;
				end
			end
			if (p >= 4 && !last && (b < 8'h20 || b > 8'h7E))
				scan_printable = 1'b0;
		end
		if (p <= PKT_MAX)
			scan_pos = 11'(p + 1);
		if (last) begin
			v = '0;
			len = p + 1;
			if (p < PKT_MAX && len > 2) begin
				if ((scan_opcode == OP_RRQ || scan_opcode == OP_WRQ) && len > 4 &&
						b == 8'h00 && scan_nulls == 2'd2) begin
					if (scan_netascii_ok && scan_mode_len == 11'd8) begin
						v.accepted = 1'b1;
						v.mode = MODE_NETASCII;
					end else if (scan_octet_ok && scan_mode_len == 11'd5) begin
						v.accepted = 1'b1;
						v.mode = MODE_OCTET;
					end
					if (v.accepted) begin
						v.kind = (scan_opcode == OP_RRQ) ? KIND_READ : KIND_WRITE;
						v.text_length = (scan_name_len > 11'd1023) ? 10'h3FF : scan_name_len[9:0];
					end
				end else if (scan_opcode == OP_ERROR && len > 5 && b == 8'h00 &&
						scan_printable) begin
					v.accepted = 1'b1;
					v.kind = KIND_ERROR;
					v.error_code = scan_code;
					v.text_length = (len - 5 > 1023) ? 10'h3FF : 10'(len - 5);
				end
			end
			expected_verdicts.push_back(v);
			clear_scan();
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		trpp_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict with none pending, accepted", out_data.accepted, 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (out_data.accepted !== want.accepted)
					report_mismatch("accepted", out_data.accepted, want.accepted);
				if (out_data.kind !== want.kind)
					report_mismatch("kind", out_data.kind, want.kind);
				if (out_data.mode !== want.mode)
					report_mismatch("mode", out_data.mode, want.mode);
				if (out_data.error_code !== want.error_code)
					report_mismatch("error_code", out_data.error_code, want.error_code);
				if (out_data.text_length !== want.text_length)
					report_mismatch("text_length", out_data.text_length, want.text_length);
			end
		end
	end

	// receiver: long hold-offs on request, otherwise a rotating stall pattern
	always @(negedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		rx_cycle++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case ((rx_cycle / 97) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= (rx_cycle % 4) != 0;
				2: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (rx_cycle % 5) == 0;
			endcase
		end
	end

	// one byte transaction; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_data <= '{data_byte: b, is_last: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_verdict(b, last);
		@(negedge clk);
	endtask

	// send the packet held in pkt_bytes, in bursts with random gaps
	task automatic send_packet();
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
			if (!steady_send) begin
				if (burst_left != 0)
					burst_left--;
				if (burst_left == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 8);
				end
			end
		end
	endtask

	// sender stands still until every pending verdict has been taken
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// mode word with letters in random case
	task automatic push_mode(input bit octet);
		logic [7:0] c;
		int n;
		n = octet ? 5 : 8;
		for (int i = 0; i < n; i++) begin
			c = octet ? OCTET_WORD[39 - 8 * i -: 8] : NETASCII_WORD[63 - 8 * i -: 8];
			if ($urandom_range(0, 1))
				c = c & 8'hDF;
			pkt_bytes.push_back(c);
		end
	endtask

	task automatic build_request(input logic [15:0] op, input int name_len, input bit octet);
		pkt_bytes = {};
		pkt_bytes.push_back(op[15:8]);
		pkt_bytes.push_back(op[7:0]);
		repeat (name_len) pkt_bytes.push_back(8'($urandom_range(1, 255)));
		pkt_bytes.push_back(8'h00);
		push_mode(octet);
		pkt_bytes.push_back(8'h00);
	endtask

	task automatic build_error(input logic [15:0] code, input int msg_len);
		pkt_bytes = {};
		pkt_bytes.push_back(OP_ERROR[15:8]);
		pkt_bytes.push_back(OP_ERROR[7:0]);
		pkt_bytes.push_back(code[15:8]);
		pkt_bytes.push_back(code[7:0]);
		repeat (msg_len) pkt_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
		pkt_bytes.push_back(8'h00);
	endtask

	// short packets, each accepted opcode and unknown ones, both modes, extreme codes and bytes
	task automatic test_directed_packets();
		pkt_bytes = '{8'h01};
		send_packet();
		pkt_bytes = '{8'h00, 8'h01};
		send_packet();
		pkt_bytes = '{8'h00, 8'h01, 8'h00, 8'h00};
		send_packet();
		// empty filename is fine
		build_request(OP_RRQ, 0, 1'b1);
		send_packet();
		pkt_bytes = '{8'h00, 8'h02, 8'hFF, 8'h80, 8'h41, 8'h00,
			"N", "E", "T", "A", "S", "C", "I", "I", 8'h00};
		send_packet();
		pkt_bytes = '{8'h00, 8'h05, 8'h00, 8'h00, 8'h00};
		send_packet();
		pkt_bytes = '{8'h00, 8'h05, 8'hFF, 8'hFF, 8'h7E, 8'h00};
		send_packet();
		pkt_bytes = '{8'h00, 8'h05, 8'h00, 8'h00, 8'h20, 8'h20, 8'h00};
		send_packet();
		// unknown opcodes
		pkt_bytes = '{8'hFF, 8'h01, 8'h00, "o", "c", "t", "e", "t", 8'h00};
		send_packet();
		pkt_bytes = '{8'h00, 8'h03, 8'h41, 8'h00, "o", "c", "t", "e", "t", 8'h00};
		send_packet();
		// a third null spoils the request
		pkt_bytes = '{8'h00, 8'h01, 8'h41, 8'h00, "o", "c", "t", "e", "t", 8'h00, 8'h00};
		send_packet();
		// error packet whose final byte is not a null
		pkt_bytes = '{8'h00, 8'h05, 8'h12, 8'h34, 8'h41, 8'h42};
		send_packet();
	endtask

	// a well-formed error packet one byte past the size limit
	task automatic test_oversize_packets();
		build_error(16'hABCD, PKT_MAX - 4);
		send_packet();
	endtask

	// receiver holds off while short packets keep coming, so the input stalls
	task automatic test_back_pressure();
		@(negedge clk);
		hold_ask = 300;
		steady_send = 1'b1;
		repeat (40) begin
			pkt_bytes = '{8'h00, 8'($urandom_range(0, 255))};
			if ($urandom_range(0, 1))
				pkt_bytes.push_back(8'($urandom_range(0, 255)));
			send_packet();
		end
		steady_send = 1'b0;
	endtask

	// mostly well-formed packets with random content, some broken, some noise
	task automatic test_random_packets();
		int bytes_sent;
		int pick;
		int idx;
		bit octet;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			octet = 1'($urandom_range(0, 1));
			if (pick < 35) begin
				build_request($urandom_range(0, 1) ? OP_RRQ : OP_WRQ,
					($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
					octet);
			end else if (pick < 60) begin
				build_error(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 14));
			end else if (pick < 70) begin
				// mode word off by a letter, too short or too long
				build_request($urandom_range(0, 1) ? OP_RRQ : OP_WRQ, $urandom_range(0, 6), octet);
				idx = pkt_bytes.size() - 1;
				case ($urandom_range(0, 2))
					0: pkt_bytes.delete(idx - 1);
					1: pkt_bytes.insert(idx, 8'($urandom_range(8'h41, 8'h7A)));
					default: pkt_bytes[idx - 1 - $urandom_range(0, octet ? 4 : 7)] = "z";
				endcase
			end else if (pick < 77) begin
				// unprintable byte inside an error message
				build_error(16'($urandom_range(0, 16'hFFFF)), $urandom_range(1, 10));
				idx = $urandom_range(4, pkt_bytes.size() - 2);
				pkt_bytes[idx] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
					: 8'($urandom_range(8'h7F, 8'hFF));
			end else if (pick < 90) begin
				// well-formed packet with one byte changed, cut short or extended
				if ($urandom_range(0, 1))
					build_request(16'(OP_RRQ + $urandom_range(0, 1)), $urandom_range(0, 8), octet);
				else
					build_error(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 8));
				case ($urandom_range(0, 2))
					0: pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = 8'($urandom_range(0, 255));
					1: repeat ($urandom_range(1, pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
					default: repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end else begin
				// noise, often with a plausible opcode high byte
				pkt_bytes = {};
				repeat ($urandom_range(1, 10)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					pkt_bytes[0] = 8'h00;
			end
			bytes_sent += pkt_bytes.size();
			send_packet();
		end
	endtask

	// watchdog
	initial begin
		#5_000_000;
		$display("tftp_request_packet_parser_tb: errors");
		$finish;
	end

	// main sequence
	initial begin
		clear_scan();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_packets();
		wait_for_verdicts();
		test_oversize_packets();
		wait_for_verdicts();
		test_back_pressure();
		wait_for_verdicts();
		test_random_packets();
		wait_for_verdicts();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tftp_request_packet_parser_tb: clean");
		else
			$display("tftp_request_packet_parser_tb: errors");
		$finish;
	end

endmodule
